// File: rtl/core/assert_macros.svh
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/btff_pkg.sv
// Package with types and constants of the boundary tag allocator.
package btff_pkg;
  localparam int unsigned AddrW = 12;
  localparam int unsigned HeapWords = 4096;
  localparam int unsigned LenW = 13;
  localparam int unsigned TagW = LenW + 1;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [TagW-1:0] tag_t;

  typedef enum logic [1:0] {
    FUNC_FORMAT = 2'd0,
    FUNC_ALLOC  = 2'd1,
    FUNC_FREE   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FMT,
    ST_AL_RD,
    ST_AL_CHK,
    ST_AL_W1,
    ST_AL_W2,
    ST_AL_W3,
    ST_AL_W4,
    ST_AL_W5,
    ST_FR_RD0,
    ST_FR_RD1,
    ST_FR_RD2,
    ST_FR_CHK,
    ST_FR_W,
    ST_OUT
  } state_t;

  localparam logic [2:0] REG_FIRST = 3'd0;
  localparam logic [2:0] REG_LAST  = 3'd4;
endpackage

// File: rtl/core/boundary_tag_first_fit_allocator.sv
// Top level of the boundary tag first-fit heap allocator.
//
// Channel | Direction | Beat contents
// in_     | input     | tdata: func, req_words, align_log2, free_addr (from bit 0)
// out_    | output    | tdata: addr, status (from bit 0)
// cfg_    | input     | APB writes of heap_first_word (0x0), heap_last_word (0x4)
//
// Format writes the two sentinels and the head and foot of one free block,
// then gives the result beat. Allocate reads, then checks, each block walked
// over, and does up to six tag writes for the split. Free does three tag
// reads, a check and two tag writes, fewer when the address is rejected. The
// single tag memory port sets this order. One beat is in work at a time;
// reset is synchronous, and the tag memory needs no clearing pass.
`include "assert_macros.svh"
module boundary_tag_first_fit_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] func, [14:2] req_words, [18:15] align_log2, [30:19] free_addr
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [11:0] addr, [12] status
  output logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import btff_pkg::*;

  // Widths wide enough for arithmetic without wrap.
  localparam int unsigned WW = 15;
  typedef logic [WW-1:0] w_t;

  tag_t mem [HeapWords];
  tag_t rdata_r;

  addr_t cfg_first_r, cfg_last_r;
  logic  fmt_ok_r;
  w_t    lo_r, hi_r;
  state_t state_r, state_nxt;

  logic [12:0] req_r;
  logic [3:0]  lg_r;
  addr_t       fa_r;

  // Walk and write bookkeeping.
  w_t h_r, h_nxt, f_r, f_nxt, ah_r, ah_nxt, af_r, af_nxt;
  w_t nh_r, nh_nxt;
  logic [11:0] res_addr_r, res_addr_nxt;
  logic        res_st_r, res_st_nxt;
  logic [2:0]  fmt_cnt_r, fmt_cnt_nxt;

  logic        we;
  addr_t       waddr, raddr;
  tag_t        wdata;
  logic        in_acc, out_acc;

  assign cfg_pready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_acc = out_tvalid && out_tready;
  assign out_tdata = {3'b000, res_st_r, res_addr_r};

  // Register read data.
  always_comb begin
    unique case (cfg_paddr)
      REG_FIRST: cfg_prdata = {20'd0, cfg_first_r};
      REG_LAST:  cfg_prdata = {20'd0, cfg_last_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_first_r <= '0;
      cfg_last_r  <= '1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == REG_FIRST) cfg_first_r <= cfg_pwdata[11:0];
      if (cfg_paddr == REG_LAST)  cfg_last_r  <= cfg_pwdata[11:0];
    end
  end

  // Tag memory with registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // Per-block walk values derived from the tag just read.
  w_t   len, al, pp, ah_c, f_c, need;
  logic fits;
  always_comb begin
    len  = {2'b00, rdata_r[LenW-1:0]};
    al   = w_t'(1) << lg_r;
    f_c  = h_r + len - w_t'(1);
    pp   = (h_r + al) & ~(al - w_t'(1));
    ah_c = pp - w_t'(1);
    need = {2'b00, req_r} + w_t'(2);
    fits = !rdata_r[LenW] && (ah_c <= f_c) &&
           ({1'b0, need} <= {1'b0, f_c - ah_c} + 16'd1);
  end

  function automatic tag_t mk(w_t a, w_t b, logic u);
    w_t d;
    d = b - a + w_t'(1);
    return {u, d[LenW-1:0]};
  endfunction

  // Control state machine.
  always_comb begin
    state_nxt = state_r;
    h_nxt = h_r; f_nxt = f_r; ah_nxt = ah_r; af_nxt = af_r; nh_nxt = nh_r;
    res_addr_nxt = res_addr_r; res_st_nxt = res_st_r;
    fmt_cnt_nxt = fmt_cnt_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = h_r[AddrW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_addr_nxt = '0; res_st_nxt = 1'b0;
          unique case (func_t'(in_tdata[1:0]))
            FUNC_FORMAT: begin
              fmt_cnt_nxt = '0;
              state_nxt = ST_FMT;
            end
            FUNC_ALLOC: begin
              h_nxt = lo_r + w_t'(1);
              state_nxt = ST_AL_RD;
            end
            FUNC_FREE: state_nxt = ST_FR_RD0;
            default:   state_nxt = ST_OUT;
          endcase
        end
      end
      ST_FMT: begin
        // Sentinels and one free block, one tag per cycle.
        we = 1'b1;
        unique case (fmt_cnt_r[1:0])
          2'd0: begin waddr = lo_r[AddrW-1:0]; wdata = {1'b1, 13'd1}; end
          2'd1: begin waddr = hi_r[AddrW-1:0]; wdata = {1'b1, 13'd1}; end
          2'd2: begin
            waddr = addr_t'(lo_r + w_t'(1));
            wdata = mk(lo_r + w_t'(1), hi_r - w_t'(1), 1'b0);
          end
          default: begin
            waddr = addr_t'(hi_r - w_t'(1));
            wdata = mk(lo_r + w_t'(1), hi_r - w_t'(1), 1'b0);
          end
        endcase
        if (!fmt_ok_r) we = 1'b0;
        fmt_cnt_nxt = fmt_cnt_r + 3'd1;
        if (fmt_cnt_r == 3'd3 || !fmt_ok_r) state_nxt = ST_OUT;
      end
      ST_AL_RD: begin
        if (!fmt_ok_r || h_r >= hi_r) begin
          res_st_nxt = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          raddr = h_r[AddrW-1:0];
          state_nxt = ST_AL_CHK;
        end
      end
      ST_AL_CHK: begin
        if (len == '0 || len > hi_r - h_r) begin
          res_st_nxt = 1'b1;
          state_nxt = ST_OUT;
        end else if (fits) begin
          f_nxt = f_c; ah_nxt = ah_c;
          af_nxt = ah_c + need - w_t'(1);
          res_addr_nxt = pp[AddrW-1:0];
          state_nxt = ST_AL_W1;
        end else begin
          h_nxt = f_c + w_t'(1);
          state_nxt = ST_AL_RD;
        end
      end
      ST_AL_W1: begin
        we = (ah_r != h_r); waddr = h_r[AddrW-1:0];
        wdata = mk(h_r, ah_r - w_t'(1), 1'b0);
        state_nxt = ST_AL_W2;
      end
      ST_AL_W2: begin
        we = (ah_r != h_r); waddr = addr_t'(ah_r - w_t'(1));
        wdata = mk(h_r, ah_r - w_t'(1), 1'b0);
        state_nxt = ST_AL_W3;
      end
      ST_AL_W3: begin
        we = 1'b1; waddr = ah_r[AddrW-1:0]; wdata = mk(ah_r, af_r, 1'b1);
        state_nxt = ST_AL_W4;
      end
      ST_AL_W4: begin
        we = 1'b1; waddr = af_r[AddrW-1:0]; wdata = mk(ah_r, af_r, 1'b1);
        fmt_cnt_nxt = '0;
        state_nxt = ST_AL_W5;
      end
      ST_AL_W5: begin
        // Trailing excess, head then foot.
        we = (af_r != f_r);
        wdata = mk(af_r + w_t'(1), f_r, 1'b0);
        if (fmt_cnt_r[0]) begin
          waddr = f_r[AddrW-1:0];
          fmt_cnt_nxt = '0;
          state_nxt = ST_OUT;
        end else begin
          waddr = addr_t'(af_r + w_t'(1));
          fmt_cnt_nxt = 3'd1;
        end
      end
      ST_FR_RD0: begin
        h_nxt = {3'b000, fa_r} - w_t'(1);
        if (!fmt_ok_r || {3'b000, fa_r} < lo_r + w_t'(2) || {3'b000, fa_r} > hi_r)
          state_nxt = ST_OUT;
        else begin
          raddr = addr_t'({3'b000, fa_r} - w_t'(1));
          state_nxt = ST_FR_RD1;
        end
      end
      ST_FR_RD1: begin
        // Own head tag arrives; read left neighbor foot.
        if (len == '0 || len > hi_r - h_r) state_nxt = ST_OUT;
        else begin
          f_nxt = f_c;
          raddr = addr_t'(h_r - w_t'(1));
          state_nxt = ST_FR_RD2;
        end
      end
      ST_FR_RD2: begin
        // Left foot arrives; read right neighbor head.
        nh_nxt = h_r;
        if (!rdata_r[LenW] && len != '0 && len <= h_r - w_t'(1) - lo_r)
          nh_nxt = h_r - len;
        raddr = addr_t'(f_r + w_t'(1));
        state_nxt = ST_FR_CHK;
      end
      ST_FR_CHK: begin
        if (!rdata_r[LenW] && len != '0 && len <= hi_r - (f_r + w_t'(1)))
          f_nxt = f_r + len;
        h_nxt = nh_r;
        fmt_cnt_nxt = '0;
        state_nxt = ST_FR_W;
      end
      ST_FR_W: begin
        we = 1'b1; wdata = mk(h_r, f_r, 1'b0);
        if (fmt_cnt_r[0]) begin
          waddr = f_r[AddrW-1:0];
          state_nxt = ST_OUT;
        end else begin
          waddr = h_r[AddrW-1:0];
          fmt_cnt_nxt = 3'd1;
        end
      end
      ST_OUT: if (out_acc) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fmt_ok_r <= 1'b0;
      lo_r <= '0; hi_r <= '0;
      fmt_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      fmt_cnt_r <= fmt_cnt_nxt;
      if (in_acc && func_t'(in_tdata[1:0]) == FUNC_FORMAT) begin
        fmt_ok_r <= ({3'b000, cfg_last_r} >= {3'b000, cfg_first_r} + w_t'(2));
        lo_r <= {3'b000, cfg_first_r};
        hi_r <= {3'b000, cfg_last_r};
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_tdata[14:2];
      lg_r   <= in_tdata[18:15];
      fa_r   <= in_tdata[30:19];
    end
    h_r <= h_nxt; f_r <= f_nxt; ah_r <= ah_nxt; af_r <= af_nxt;
    nh_r <= nh_nxt;
    res_addr_r <= res_addr_nxt; res_st_r <= res_st_nxt;
  end

  `ASSERT_NEVER(a_ready_busy, clk, rst_n, in_tready && out_tvalid)
  `ASSERT_IMPL(a_fail_addr, clk, rst_n, (out_tvalid && res_st_r) |-> (res_addr_r == '0))
  `ASSERT_IMPL(a_hold, clk, rst_n, (out_tvalid && !out_tready) |=> out_tvalid)
  `ASSERT_NEVER(a_write_idle, clk, rst_n, we && (state_r == ST_IDLE || state_r == ST_OUT))
endmodule

// File: bench/heap_result_checker.sv
// Checker for the boundary tag allocator: mirrors the heap tags and compares result beats.
module heap_result_checker
  import btff_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatch_count,
  output int          replies_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] LenMask = 32'h7FFF_FFFF;

  typedef struct packed {
    addr_t addr;
    logic  status;
  } reply_t;

  // Mirror of the tag memory; a word is flagged once it has been written.
  logic [31:0] tag_mirror [HeapWords];
  bit          tag_written [HeapWords];
  int unsigned first_reg, last_reg;
  int unsigned lo_sent, hi_sent;
  bit          heap_ready;
  int unsigned live_blocks[$];
  reply_t      expected_replies[$];

  function automatic void put_tag(int unsigned i, logic [31:0] v);
    if (i < HeapWords) begin
      tag_mirror[i] = v;
      tag_written[i] = 1'b1;
    end
  endfunction

  function automatic logic [31:0] get_tag(int unsigned i, inout bit known);
    if (i >= HeapWords) return '0;
    if (!tag_written[i]) known = 1'b0;
    return tag_mirror[i];
  endfunction

  function automatic void put_block(int unsigned h, int unsigned f, bit used);
    logic [31:0] t;
    t = ((f - h + 1) & LenMask) | (used ? 32'h8000_0000 : 32'h0);
    put_tag(h, t);
    put_tag(f, t);
  endfunction

  // First-fit walk; reports whether every tag it read had been written.
  function automatic bit find_fit(input int unsigned need, input int unsigned al,
                                  output int unsigned bh, output int unsigned bah,
                                  output int unsigned bf, output bit known);
    int unsigned h, len, f, p, ah;
    logic [31:0] t;
    known = 1'b1;
    bh = 0;
    bah = 0;
    bf = 0;
    if (!heap_ready) return 1'b0;
    h = lo_sent + 1;
    while (h < hi_sent) begin
      t = get_tag(h, known);
      len = t & LenMask;
      if (len == 0 || len > hi_sent - h) return 1'b0;
      f = h + len - 1;
      p = (h + 1 + al - 1) & ~(al - 1);
      ah = p - 1;
      if (!t[31] && ah <= f && need <= f - ah + 1) begin
        bh = h;
        bah = ah;
        bf = f;
        return 1'b1;
      end
      h = f + 1;
    end
    return 1'b0;
  endfunction

  // Release with neighbor merge; a dry run only checks that its reads are known.
  function automatic bit release_block(int unsigned pa, bit dry);
    int unsigned h, f, len, ll, rl;
    logic [31:0] t;
    bit known;
    known = 1'b1;
    if (!heap_ready || pa < lo_sent + 2 || pa > hi_sent) return 1'b1;
    h = pa - 1;
    len = get_tag(h, known) & LenMask;
    if (len == 0 || len > hi_sent - h) return known;
    f = h + len - 1;
    t = get_tag(h - 1, known);
    if (!t[31]) begin
      ll = t & LenMask;
      if (ll != 0 && ll <= h - 1 - lo_sent) h = h - ll;
    end
    t = get_tag(f + 1, known);
    if (!t[31]) begin
      rl = t & LenMask;
      if (rl != 0 && rl <= hi_sent - (f + 1)) f = f + rl;
    end
    if (dry) return known;
    put_block(h, f, 1'b0);
    foreach (live_blocks[k]) begin
      if (live_blocks[k] == pa) begin
        live_blocks.delete(k);
        break;
      end
    end
    return known;
  endfunction

  // True when the beat reads no tag word that was never written.
  function automatic bit beat_is_safe(logic [31:0] d);
    int unsigned bh, bah, bf;
    bit known, fit;
    case (func_t'(d[1:0]))
      FUNC_ALLOC: begin
        fit = find_fit(d[14:2] + 2, 32'd1 << d[18:15], bh, bah, bf, known);
        return known;
      end
      FUNC_FREE: return release_block(d[30:19], 1'b1);
      default: return 1'b1;
    endcase
  endfunction

  function automatic int unsigned pick_live_block();
    if (live_blocks.size() == 0) return 0;
    return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
  endfunction

  // Applies one input beat to the mirror and returns the reply it must cause.
  function automatic reply_t predict_heap_reply(logic [31:0] d);
    reply_t r;
    int unsigned need, al, bh, bah, bf, bfoot;
    bit known, ok;
    r = '0;
    case (func_t'(d[1:0]))
      FUNC_FORMAT: begin
        heap_ready = 1'b0;
        live_blocks.delete();
        if (last_reg < HeapWords && last_reg >= first_reg + 2) begin
          put_tag(first_reg, 32'h8000_0001);
          put_tag(last_reg, 32'h8000_0001);
          put_block(first_reg + 1, last_reg - 1, 1'b0);
          lo_sent = first_reg;
          hi_sent = last_reg;
          heap_ready = 1'b1;
        end
      end
      FUNC_ALLOC: begin
        need = d[14:2] + 2;
        al = 32'd1 << d[18:15];
        if (find_fit(need, al, bh, bah, bf, known)) begin
          bfoot = bah + need - 1;
          if (bah != bh) put_block(bh, bah - 1, 1'b0);
          put_block(bah, bfoot, 1'b1);
          if (bfoot != bf) put_block(bfoot + 1, bf, 1'b0);
          r.addr = addr_t'(bah + 1);
          live_blocks.push_back(bah + 1);
        end else begin
          r.status = 1'b1;
        end
      end
      FUNC_FREE: ok = release_block(d[30:19], 1'b0);
      default: ;
    endcase
    return r;
  endfunction

  // Compare result beats first, then predict the accepted input beat.
  always_ff @(posedge clk) begin
    reply_t want, got;
    if (!rst_n) begin
      first_reg <= 0;
      last_reg <= 4095;
      lo_sent = 0;
      hi_sent = 0;
      heap_ready = 1'b0;
      mismatch_count <= 0;
      replies_pending <= 0;
      expected_replies.delete();
      live_blocks.delete();
      for (int i = 0; i < HeapWords; i++) begin
        tag_mirror[i] = '0;
        tag_written[i] = 1'b0;
      end
    end else begin
      if (out_tvalid && out_tready) begin
        got.addr = out_tdata[11:0];
        got.status = out_tdata[12];
        if (expected_replies.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("result beat with nothing expected: addr %0d status %0d",
                     got.addr, got.status);
        end else begin
          want = expected_replies.pop_front();
          if (want !== got) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("result mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                       want.addr, want.status, got.addr, got.status);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_replies.push_back(predict_heap_reply(in_tdata));
      replies_pending <= expected_replies.size();
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == REG_FIRST) first_reg <= cfg_pwdata[11:0];
        else if (cfg_paddr == REG_LAST) last_reg <= cfg_pwdata[11:0];
      end
    end
  end

  final begin
  end
endmodule

// File: bench/tb_boundary_tag_first_fit_allocator.sv
// Testbench top: drives the allocator with directed and random beats and reports the verdict.
module tb_boundary_tag_first_fit_allocator;
  import btff_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 60000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [15:0] out_tdata;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;
  int          mismatch_count, replies_pending;
  logic        in_beat_taken, out_beat_taken;
  bit          no_idle;
  int          quiet_cycles;

  boundary_tag_first_fit_allocator u_dut (.*);

  heap_result_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_pready, .mismatch_count, .replies_pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Handshake flags seen at the rising edge, read back at the falling edge.
  always_ff @(posedge clk) begin
    in_beat_taken <= in_tvalid && in_tready;
    out_beat_taken <= out_tvalid && out_tready;
  end

  // Watchdog on cycles without any accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("boundary_tag_first_fit_allocator verification failed");
        $finish;
      end
    end
  end

  // Receiver: a random stall, which may be zero and is zero while no_idle is set, before each result beat.
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (!out_beat_taken);
    end
  end

  function automatic logic [31:0] pack_beat(func_t fn, int unsigned req,
                                            int unsigned lg, int unsigned fa);
    logic [31:0] d;
    d = '0;
    d[1:0] = fn;
    d[14:2] = req[12:0];
    d[18:15] = lg[3:0];
    d[30:19] = fa[11:0];
    return d;
  endfunction

  // Sends one beat; a beat that would read unwritten tags goes out as a no-op.
  task automatic send_beat(logic [31:0] d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (!u_chk.beat_is_safe(d)) d = pack_beat(FUNC_NOP, $urandom, $urandom, $urandom);
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(negedge clk); while (!in_beat_taken);
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (replies_pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(logic [2:0] idx, int unsigned value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= idx;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random_beat();
    int unsigned pick, req, lg, fa;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      req = $urandom_range(0, 99);
      if (req < 70) req = $urandom_range(0, 24);
      else if (req < 92) req = $urandom_range(25, 300);
      else if (req < 98) req = $urandom_range(301, 2000);
      else req = $urandom_range(2001, 4096);
      lg = $urandom_range(0, 99);
      if (lg < 60) lg = $urandom_range(0, 2);
      else if (lg < 90) lg = $urandom_range(3, 6);
      else lg = $urandom_range(7, 15);
      send_beat(pack_beat(FUNC_ALLOC, req, lg, $urandom));
    end else if (pick < 92) begin
      fa = u_chk.pick_live_block();
      if (pick >= 80 || fa == 0) begin
        if ($urandom_range(0, 3) == 0) fa = $urandom_range(0, 4095);
        else fa = $urandom_range(u_chk.lo_sent, u_chk.hi_sent + 2);
      end
      send_beat(pack_beat(FUNC_FREE, $urandom, $urandom, fa));
    end else if (pick < 98) begin
      send_beat(pack_beat(FUNC_NOP, $urandom, $urandom, $urandom));
    end else begin
      send_beat(pack_beat(FUNC_FORMAT, $urandom, $urandom, $urandom));
    end
  endtask

  initial begin
    int unsigned lo_list[8];
    int unsigned hi_list[8];
    rst_n = 1'b0;
    no_idle = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: unformatted heap, no-op, full-size and aligned requests, edge frees.
    send_beat(pack_beat(FUNC_ALLOC, 5, 0, 0));
    send_beat(pack_beat(FUNC_FREE, 0, 0, 100));
    send_beat(pack_beat(FUNC_NOP, 8191, 15, 4095));
    send_beat(pack_beat(FUNC_FORMAT, 0, 0, 0));
    send_beat(pack_beat(FUNC_ALLOC, 0, 0, 0));
    send_beat(pack_beat(FUNC_ALLOC, 4096, 0, 0));
    send_beat(pack_beat(FUNC_FREE, 0, 0, 2));
    send_beat(pack_beat(FUNC_ALLOC, 4092, 0, 0));
    send_beat(pack_beat(FUNC_FREE, 0, 0, 2));
    send_beat(pack_beat(FUNC_ALLOC, 10, 12, 0));
    send_beat(pack_beat(FUNC_ALLOC, 10, 15, 0));
    send_beat(pack_beat(FUNC_ALLOC, 10, 11, 0));
    send_beat(pack_beat(FUNC_ALLOC, 1, 3, 0));
    send_beat(pack_beat(FUNC_FREE, 0, 0, 0));
    send_beat(pack_beat(FUNC_FREE, 0, 0, 4095));
    send_beat(pack_beat(FUNC_FREE, 0, 0, 2048));
    send_beat(pack_beat(FUNC_FREE, 0, 0, 8));
    send_beat(pack_beat(FUNC_ALLOC, 3000, 0, 0));

    // Random phases over several heap bounds, the extremes among them.
    lo_list = '{0, 0, 4093, 50, 4000, 100, 1234, 0};
    hi_list = '{4095, 2, 4095, 51, 4095, 600, 3000, 4095};
    for (int ph = 0; ph < 8; ph++) begin
      drain_replies();
      write_reg(REG_FIRST, lo_list[ph]);
      write_reg(REG_LAST, hi_list[ph]);
      send_beat(pack_beat(FUNC_FORMAT, 0, 0, 0));
      for (int n = 0; n < 180; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (ph == 1 && n == 90) drain_replies();
        send_random_beat();
      end
    end

    no_idle = 1'b0;
    drain_replies();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && replies_pending == 0)
      $display("boundary_tag_first_fit_allocator verification clean");
    else
      $display("boundary_tag_first_fit_allocator verification failed");
    $finish;
  end
endmodule
